// ===== hw/rtl/ole_pkg.sv =====
// ole_pkg: shared constants, codes and the cell control struct of the ordered list engine
// no dependencies; used by ole_cell and ordered_list_engine

package ole_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 8;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_PUSH   = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADPOS   = 2'd3
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic             scan_start;
    logic             scan_step;
    logic             scan_end;
    logic [IDX_W-1:0] ins_idx;
  } ole_ctl_t;

endpackage

// ===== hw/rtl/ordered_list_engine.sv =====
// ordered_list_engine: top level, request decode, delete scan control and result register
// depends on ole_pkg and ole_cell

// Ordered list of up to DEPTH signed 32-bit values held in a row of cells, head in
// cell 0. Append, push and insert-at-index complete in the cycle they are accepted:
// every cell takes its left neighbour or the new word in parallel, so these run
// at one word per cycle while the result word is not stalled. Delete sends a token
// down the row one cell per cycle and holds off new requests until the token finds
// the first match or passes the last entry; on a match all later cells shift toward
// the head together. Every request gives one result word, held in a single output
// register: a new request is taken only in a cycle where that word is empty or
// leaving, so a stalled result also holds off the input.

module ordered_list_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [1:0] req_type, [33:2] item_value, [37:34] position, [39:38] zero
  input  logic [ole_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [1:0] status, [6:2] entry_count, [7] zero
  output logic [ole_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import ole_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [DATA_W-1:0] key_q;
  logic              m_valid_q;
  status_e           status_q;
  logic [4:0]        count_out_q;

  req_e              req_type;
  logic [DATA_W-1:0] item_value;
  logic [3:0]        position;

  logic              in_fire;
  logic              out_free;
  logic              full;
  logic              bad_pos;
  logic              hit;
  logic              miss;
  logic              done;
  logic              res_load;
  ole_ctl_t          ctl;
  logic [DATA_W-1:0] word;

  logic [DATA_W-1:0] value_w [DEPTH];
  logic [DEPTH-1:0]  valid_w;
  logic [DEPTH-1:0]  probe_w;
  logic [DEPTH-1:0]  eq_w;

  assign req_type   = req_e'(s_axis_tdata_i[1:0]);
  assign item_value = s_axis_tdata_i[33:2];
  assign position   = s_axis_tdata_i[37:34];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign bad_pos = (CMP_W'(position) >= CMP_W'(count_q));

  assign hit  = |(probe_w & eq_w);
  assign miss = |(probe_w & ~valid_w) | (probe_w[DEPTH-1] & ~eq_w[DEPTH-1]);
  assign done = hit || miss;

  // a result word is produced this cycle
  assign res_load = (state_q == S_IDLE) ? (in_fire && (req_type != REQ_DELETE))
                                        : (done && out_free);

  assign word = (state_q == S_SCAN) ? key_q : item_value;

  always_comb begin
    ctl = '0;
    case (req_type)
      REQ_APPEND: ctl.ins_idx = count_q[IDX_W-1:0];
      REQ_PUSH:   ctl.ins_idx = '0;
      REQ_INSERT: ctl.ins_idx = IDX_W'(position);
      default:    ctl.ins_idx = '0;
    endcase
    if (state_q == S_IDLE) begin
      if (in_fire) begin
        if (req_type == REQ_DELETE) begin
          ctl.scan_start = 1'b1;
        end else if (!full && !(req_type == REQ_INSERT && bad_pos)) begin
          ctl.insert = 1'b1;
        end
      end
    end else begin
      if (done && out_free) begin
        ctl.scan_end = 1'b1;
        ctl.remove   = hit;
      end else if (!done) begin
        ctl.scan_step = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] left_value;
    logic              left_valid;
    logic              left_probe;
    logic [DATA_W-1:0] right_value;
    logic              right_valid;

    if (k == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_probe = 1'b0;
    end else begin : g_mid_l
      assign left_value = value_w[k-1];
      assign left_valid = valid_w[k-1];
      assign left_probe = probe_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_value = value_w[k+1];
      assign right_valid = valid_w[k+1];
    end

    ole_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .cell_idx_i    (IDX_W'(k)),
      .word_i        (word),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .left_probe_i  (left_probe),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .value_o       (value_w[k]),
      .valid_o       (valid_w[k]),
      .probe_o       (probe_w[k]),
      .eq_o          (eq_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      m_valid_q   <= 1'b0;
      status_q    <= ST_OK;
      count_out_q <= '0;
      key_q       <= '0;
    end else begin
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (req_type == REQ_DELETE) begin
              key_q   <= item_value;
              state_q <= S_SCAN;
            end else begin
              if (full) begin
                status_q    <= ST_FULL;
                count_out_q <= 5'(count_q);
              end else if (req_type == REQ_INSERT && bad_pos) begin
                status_q    <= ST_BADPOS;
                count_out_q <= 5'(count_q);
              end else begin
                status_q    <= ST_OK;
                count_q     <= count_q + CNT_W'(1);
                count_out_q <= 5'(count_q + CNT_W'(1));
              end
            end
          end
        end
        S_SCAN: begin
          if (done && out_free) begin
            state_q   <= S_IDLE;
            if (hit) begin
              status_q    <= ST_OK;
              count_q     <= count_q - CNT_W'(1);
              count_out_q <= 5'(count_q - CNT_W'(1));
            end else begin
              status_q    <= ST_NOTFOUND;
              count_out_q <= 5'(count_q);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, count_out_q, status_q};

`ifndef SYNTHESIS
  // occupied cells always agree with the entry count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == 32'(count_q))
    else $error("valid cells disagree with entry count");

  // a scan always has exactly one token in the row, otherwise none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> $onehot(probe_w))
    else $error("scan token lost or duplicated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (probe_w == '0))
    else $error("token left in the row while idle");

  // a successful insert grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.insert |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not bump entry count");

  // a match always shrinks the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.remove |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("delete did not drop entry count");
`endif

endmodule

// ===== hw/rtl/ole_cell.sv =====
// ole_cell: one list slot holding a value, its valid flag and the delete scan token
// depends on ole_pkg; instantiated in a row by ordered_list_engine

module ole_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ole_pkg::ole_ctl_t         ctl_i,
  input  logic [ole_pkg::IDX_W-1:0] cell_idx_i,
  input  logic [ole_pkg::DATA_W-1:0] word_i,
  input  logic [ole_pkg::DATA_W-1:0] left_value_i,
  input  logic                      left_valid_i,
  input  logic                      left_probe_i,
  input  logic [ole_pkg::DATA_W-1:0] right_value_i,
  input  logic                      right_valid_i,
  output logic [ole_pkg::DATA_W-1:0] value_o,
  output logic                      valid_o,
  output logic                      probe_o,
  output logic                      eq_o
);
  import ole_pkg::*;

  logic [DATA_W-1:0] value_q;
  logic              valid_q;
  logic              probe_q;
  logic              passed_q;

  // payload: shifts toward the tail on insert, toward the head on delete
  always_ff @(posedge clk_i) begin
    if (ctl_i.insert) begin
      if (cell_idx_i > ctl_i.ins_idx) begin
        value_q <= left_value_i;
      end else if (cell_idx_i == ctl_i.ins_idx) begin
        value_q <= word_i;
      end
    end else if (ctl_i.remove && !passed_q) begin
      value_q <= right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      probe_q  <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      if (ctl_i.insert) begin
        if (cell_idx_i > ctl_i.ins_idx) begin
          valid_q <= left_valid_i;
        end else if (cell_idx_i == ctl_i.ins_idx) begin
          valid_q <= 1'b1;
        end
      end else if (ctl_i.remove && !passed_q) begin
        valid_q <= right_valid_i;
      end
      // token walks from the head, leaving a trail of passed cells behind it
      if (ctl_i.scan_start) begin
        probe_q  <= (cell_idx_i == '0);
        passed_q <= 1'b0;
      end else if (ctl_i.scan_end) begin
        probe_q  <= 1'b0;
        passed_q <= 1'b0;
      end else if (ctl_i.scan_step) begin
        probe_q  <= left_probe_i;
        passed_q <= passed_q | probe_q;
      end
    end
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign probe_o = probe_q;
  assign eq_o    = valid_q && (value_q == word_i);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for ordered_list_engine, directed list edits then random traffic
// keeps a software copy of the list to predict each status and entry count
// depends on ole_pkg and ordered_list_engine

module tb_top;
  import ole_pkg::*;

  localparam int unsigned STUCK_LIMIT = 4000;

  typedef struct {
    status_e    status;
    logic [4:0] count;
  } list_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;

  // software copy of the list, head at index 0
  logic [DATA_W-1:0] list_mirror [DEPTH];
  int                list_len = 0;
  list_result_t      pending_results [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stuck_cycles   = 0;

  ordered_list_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // applies one request to the list copy and returns what the engine must answer
  function automatic list_result_t apply_list_request(input req_e req,
                                                      input logic [DATA_W-1:0] value,
                                                      input logic [3:0] pos);
    list_result_t r;
    int           hit;
    int           slot;
    r.status = ST_OK;
    hit      = -1;
    slot     = 0;
    if (req == REQ_DELETE) begin
      for (int k = 0; k < list_len; k++)
        if (hit < 0 && list_mirror[k] == value) hit = k;
      if (hit < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        for (int k = hit; k + 1 < list_len; k++) list_mirror[k] = list_mirror[k + 1];
        list_len--;
      end
    end else if (list_len >= DEPTH) begin
      r.status = ST_FULL;
    end else if (req == REQ_INSERT && int'(pos) >= list_len) begin
      r.status = ST_BADPOS;
    end else begin
      if (req == REQ_APPEND) slot = list_len;
      else if (req == REQ_INSERT) slot = int'(pos);
      for (int k = list_len; k > slot; k--) list_mirror[k] = list_mirror[k - 1];
      list_mirror[slot] = value;
      list_len++;
    end
    r.count = list_len[4:0];
    return r;
  endfunction

  // sends one request word and records its expected answer once accepted
  task automatic send_request(input req_e req, input logic [DATA_W-1:0] value,
                              input logic [3:0] pos);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, pos, value, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_list_request(req, value, pos));
  endtask

  // result side: random back-pressure and in-order comparison
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with no request pending", m_axis_tdata_o));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] != want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_axis_tdata_o[1:0], want.status));
        if (m_axis_tdata_o[6:2] != want.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    m_axis_tdata_o[6:2], want.count));
      end
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    int v;
    v = 0;
    case ($urandom_range(0, 9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2, 3, 4: v = int'($urandom_range(0, 7)) - 4;  // small pool, forces duplicates
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_empty_list();
    send_request(REQ_DELETE, '0, 4'd0);
    send_request(REQ_INSERT, 32'h0000_1234, 4'd0);
    send_request(REQ_INSERT, 32'hffff_ffff, 4'd15);
  endtask

  task automatic test_edit_ops();
    send_request(REQ_APPEND, 32'h7fff_ffff, 4'd0);
    send_request(REQ_PUSH,   32'h8000_0000, 4'd15);
    send_request(REQ_APPEND, 32'h0000_0000, 4'd0);
    send_request(REQ_INSERT, 32'hffff_ffff, 4'd0);   // index 0 behaves as a head push
    send_request(REQ_INSERT, 32'd5, 4'd2);
    send_request(REQ_INSERT, 32'd5, 4'd4);           // last valid index, duplicate value
    send_request(REQ_INSERT, 32'd9, 4'd6);           // index equal to count
    send_request(REQ_DELETE, 32'd5, 4'd0);           // only the first match goes
    send_request(REQ_DELETE, 32'h0000_0000, 4'd0);   // tail entry
    send_request(REQ_DELETE, 32'hffff_ffff, 4'd0);   // head entry
    send_request(REQ_DELETE, 32'h7fff_fffe, 4'd0);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH) begin
      if (list_len % 2) send_request(REQ_PUSH, 32'h1000_0000 + list_len, 4'd3);
      else send_request(REQ_APPEND, 32'h1000_0000 + list_len, 4'd0);
    end
    send_request(REQ_APPEND, 32'h2222_2222, 4'd0);
    send_request(REQ_PUSH,   32'h3333_3333, 4'd0);
    send_request(REQ_INSERT, 32'h4444_4444, 4'd15);
    send_request(REQ_DELETE, 32'h7fff_fffe, 4'd0);   // scan runs the whole row
    send_request(REQ_DELETE, list_mirror[list_len - 1], 4'd0);
    send_request(REQ_DELETE, list_mirror[0], 4'd0);
  endtask

  // picks fill-biased or drain-biased runs at random so both full and empty lists recur
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
    bit   filling;
    int   run_left;
    req_e req;
    logic [DATA_W-1:0] value;
    logic [3:0]        pos;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    filling  = 1'b1;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        filling  = 1'($urandom_range(0, 1));
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      if ($urandom_range(0, 99) < (filling ? 85 : 20)) begin
        case ($urandom_range(0, 2))
          0:       req = REQ_APPEND;
          1:       req = REQ_PUSH;
          default: req = REQ_INSERT;
        endcase
        value = pick_value();
      end else begin
        req = REQ_DELETE;
        if (list_len > 0 && $urandom_range(0, 99) < 85)
          value = list_mirror[$urandom_range(0, list_len - 1)];
        else
          value = pick_value();
      end
      if (list_len > 0 && $urandom_range(0, 99) < 75)
        pos = 4'($urandom_range(0, list_len - 1));
      else
        pos = 4'($urandom_range(0, 15));
      send_request(req, value, pos);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_edit_ops();
    test_full_list();
    test_random_traffic(0, 0, 330);
    test_random_traffic(84, 0, 330);
    test_random_traffic(0, 84, 330);
    test_random_traffic(17, 17, 330);
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ole_pkg.sv
hw/rtl/ole_cell.sv
hw/rtl/ordered_list_engine.sv
tb/sv/tb_top.sv
